// ===== hdl/greedy_minutiae_pairing_assert.svh =====
// Assertion macros for the minutiae pairing checker
`ifndef GREEDY_MINUTIAE_PAIRING_ASSERT_SVH
`define GREEDY_MINUTIAE_PAIRING_ASSERT_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define GMP_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GMP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/gmp_pkg.sv =====
// Types and constants of the greedy minutiae pairing block
package gmp_pkg;

    localparam int MAX_MINUTIAE = 256;
    localparam int COORD_BITS   = 14;
    localparam int DIR_W        = 8;
    localparam int D2_W         = 2 * COORD_BITS + 1;
    localparam int RADIUS_W     = 10;
    localparam int RADIUS_RESET = 10;
    localparam int FOLD_W       = 8;
    localparam int FOLD_SQ_W    = 15;
    localparam int FULL_TURN    = 360;
    localparam int HALF_TURN    = 180;
    localparam int Q_SHIFT      = 16;

    localparam logic [1:0] MODE_LOAD_FIRST  = 2'd0;
    localparam logic [1:0] MODE_LOAD_SECOND = 2'd1;
    localparam logic [1:0] MODE_COMPARE     = 2'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [13:0] x_pos;
        logic [13:0] y_pos;
        logic [7:0]  direction;
        logic [3:0]  finger_first;
        logic [3:0]  finger_second;
    } t_item;

    typedef struct packed {
        logic [8:0]  count_first;
        logic [8:0]  count_second;
        logic [8:0]  common_count;
        logic [16:0] ratio_q16;
        logic [17:0] mean_distance_q8;
        logic [15:0] rms_angle_q8;
        logic        overflow;
    } t_result;

    typedef struct packed {
        logic                  valid;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
    } t_query;

    typedef struct packed {
        logic             valid;
        logic             found;
        logic [D2_W-1:0]  d2;
        logic [DIR_W-1:0] dir;
    } t_best;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PASS,
        ST_READ,
        ST_QUERY,
        ST_WAIT,
        ST_DSQRT,
        ST_RATIO,
        ST_MEAN,
        ST_ADIV,
        ST_ASQRT,
        ST_OUT
    } t_state;

endpackage

// ===== hdl/gmp_ram.sv =====
// Generic single-port-write RAM with registered read
module gmp_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 256
) (
    input  logic                                 i_clk,
    input  logic                                 i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                     i_wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                     o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/gmp_cell.sv =====
// One second-set minutia cell of the nearest-neighbor search chain
module gmp_cell #(
    parameter int IDX_W    = 8,
    parameter int CNT_W    = 9,
    parameter int CELL_IDX = 0
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_wr_en,
    input  logic [IDX_W-1:0]               i_wr_idx,
    input  logic [gmp_pkg::COORD_BITS-1:0] i_wr_x,
    input  logic [gmp_pkg::COORD_BITS-1:0] i_wr_y,
    input  logic [gmp_pkg::DIR_W-1:0]      i_wr_dir,
    input  logic [CNT_W-1:0]               i_fill,
    input  logic                           i_clr,
    input  logic                           i_mark_en,
    input  logic [IDX_W-1:0]               i_mark_idx,
    input  gmp_pkg::t_query                i_query,
    output gmp_pkg::t_query                o_query,
    input  gmp_pkg::t_best                 i_best,
    input  logic [IDX_W-1:0]               i_best_idx,
    output gmp_pkg::t_best                 o_best,
    output logic [IDX_W-1:0]               o_best_idx
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);
    localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(CELL_IDX);
    localparam int CW = gmp_pkg::COORD_BITS;

    logic [CW-1:0]                 r_x;
    logic [CW-1:0]                 r_y;
    logic [gmp_pkg::DIR_W-1:0]     r_dir;
    logic                          r_paired;
    gmp_pkg::t_query               r_query;
    logic [gmp_pkg::D2_W-1:0]      r_d2;
    logic                          r_elig;
    gmp_pkg::t_best                r_best;
    logic [IDX_W-1:0]              r_best_idx;

    logic [CW-1:0]                 dx;
    logic [CW-1:0]                 dy;
    logic [gmp_pkg::D2_W-1:0]      d2;
    logic                          take;
    gmp_pkg::t_best                n_best;
    logic [IDX_W-1:0]              n_best_idx;

    always_comb begin
        dx = (i_query.x > r_x) ? i_query.x - r_x : r_x - i_query.x;
        dy = (i_query.y > r_y) ? i_query.y - r_y : r_y - i_query.y;
        d2 = gmp_pkg::D2_W'(dx) * gmp_pkg::D2_W'(dx) + gmp_pkg::D2_W'(dy) * gmp_pkg::D2_W'(dy);
    end

    // best arrives in the cycle after the query: r_d2 lines up with i_best
    always_comb begin
        take = i_best.valid && r_elig && (!i_best.found || (r_d2 < i_best.d2));
        n_best = i_best;
        n_best_idx = i_best_idx;
        if (take) begin
            n_best.found = 1'b1;
            n_best.d2 = r_d2;
            n_best.dir = r_dir;
            n_best_idx = MY_IDX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_paired <= 1'b0;
            r_query <= '0;
            r_best <= '0;
        end else begin
            if (i_clr) begin
                r_paired <= 1'b0;
            end else if (i_mark_en && (i_mark_idx == MY_IDX)) begin
                r_paired <= 1'b1;
            end
            r_query <= i_query;
            r_best <= n_best;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en && (i_wr_idx == MY_IDX)) begin
            r_x <= i_wr_x;
            r_y <= i_wr_y;
            r_dir <= i_wr_dir;
        end
        r_d2 <= d2;
        r_elig <= (MY_CNT < i_fill) && !r_paired;
        r_best_idx <= n_best_idx;
    end

    assign o_query = r_query;
    assign o_best = r_best;
    assign o_best_idx = r_best_idx;

endmodule

// ===== hdl/gmp_div.sv =====
// Restoring divider, one quotient bit per cycle
module gmp_div #(
    parameter int NW = 40,
    parameter int DW = 9
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quot
);

    localparam int CW = $clog2(NW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_quo;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;

    logic [DW:0]   shifted;
    logic          fits;
    logic [DW:0]   diff;

    always_comb begin
        shifted = {r_rem, r_quo[NW-1]};
        fits = shifted >= {1'b0, r_den};
        diff = shifted - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CW'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt <= CW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_quo <= {r_quo[NW-2:0], fits};
            r_rem <= fits ? diff[DW-1:0] : shifted[DW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

// ===== hdl/gmp_sqrt.sv =====
// Restoring integer square root, two radicand bits per cycle
module gmp_sqrt #(
    parameter int SW = 46
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [SW-1:0]   i_rad,
    output logic            o_done,
    output logic [SW/2-1:0] o_root
);

    localparam int RW = SW / 2;
    localparam int CW = $clog2(RW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [SW-1:0] r_rad;
    logic [RW+1:0] r_rem;
    logic [RW-1:0] r_root;

    logic [RW+1:0] rem2;
    logic [RW+1:0] trial;
    logic          fits;

    always_comb begin
        rem2 = {r_rem[RW-1:0], r_rad[SW-1:SW-2]};
        trial = {r_root, 2'b01};
        fits = rem2 >= trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CW'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt <= CW'(RW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad <= i_rad;
            r_rem <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad <= {r_rad[SW-3:0], 2'b00};
            r_rem <= fits ? rem2 - trial : rem2;
            r_root <= {r_root[RW-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// ===== hdl/greedy_minutiae_pairing.sv =====
// Top level of the greedy minutiae pairing block
// Loads are taken back to back while idle: first-set minutiae go to a RAM,
// second-set minutiae into a row of MAX_MINUTIAE search cells. A compare runs
// passes r = 0..radius, ending early once either set is fully paired; in each
// pass every unpaired first-set minutia is read from the RAM and sent down the
// cell chain, which returns the nearest unpaired second-set minutia; a pair
// formed adds a square root. A serial divide (one bit per cycle) then builds
// the ratio and, if any pair formed, two more divides and a square root build
// the rest of the result. No clearing pass follows reset. The result sits
// in an output register, so loads of the next comparison are taken while it
// waits; the next compare runs, but its result waits until that register is free.
module greedy_minutiae_pairing #(
    parameter int MAX_MINUTIAE = gmp_pkg::MAX_MINUTIAE
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  gmp_pkg::t_item                 i_item,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output gmp_pkg::t_result               o_result,
    input  logic                           i_cfg_wr_en,
    input  logic [gmp_pkg::RADIUS_W-1:0]   i_cfg_wr_data
);

    localparam int CNT_W   = $clog2(MAX_MINUTIAE + 1);
    localparam int IDX_W   = (MAX_MINUTIAE > 1) ? $clog2(MAX_MINUTIAE) : 1;
    localparam int CW      = gmp_pkg::COORD_BITS;
    localparam int DIRW    = gmp_pkg::DIR_W;
    localparam int D2W     = gmp_pkg::D2_W;
    localparam int RADW    = gmp_pkg::RADIUS_W;
    localparam int QS      = gmp_pkg::Q_SHIFT;
    localparam int A_W     = gmp_pkg::FOLD_SQ_W + CNT_W;
    localparam int SQ_RAW  = ((D2W + QS) > (A_W + QS)) ? (D2W + QS) : (A_W + QS);
    localparam int SQ_W    = SQ_RAW + (SQ_RAW % 2);
    localparam int RT_W    = SQ_W / 2;
    localparam int DS_W    = RT_W + CNT_W;
    localparam int NW_A    = (DS_W > (A_W + QS)) ? DS_W : (A_W + QS);
    localparam int NW      = (NW_A > (CNT_W + QS)) ? NW_A : (CNT_W + QS);
    localparam int ENT_W   = 2 * CW + DIRW;
    localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_MINUTIAE);
    localparam logic [DIRW:0] FULL_C = (DIRW + 1)'(gmp_pkg::FULL_TURN);
    localparam logic [DIRW:0] HALF_C = (DIRW + 1)'(gmp_pkg::HALF_TURN);

    gmp_pkg::t_state           r_state, n_state;
    logic [RADW-1:0]           r_radius, n_radius;
    logic [CNT_W-1:0]          r_n1, n_n1;
    logic [CNT_W-1:0]          r_n2, n_n2;
    logic                      r_drop, n_drop;
    logic [MAX_MINUTIAE-1:0]   r_mark1, n_mark1;
    logic [RADW:0]             r_r, n_r;
    logic [2*RADW-1:0]         r_r2, n_r2;
    logic [CNT_W-1:0]          r_i, n_i;
    logic [CNT_W-1:0]          r_common, n_common;
    logic [DS_W-1:0]           r_dsum, n_dsum;
    logic [A_W-1:0]            r_asum, n_asum;
    logic [gmp_pkg::FOLD_W-1:0] r_fold, n_fold;
    logic [DIRW-1:0]           r_qdir, n_qdir;
    gmp_pkg::t_query           r_query, n_query;
    gmp_pkg::t_best            r_seed, n_seed;
    logic                      r_mark_en, n_mark_en;
    logic [IDX_W-1:0]          r_mark_idx, n_mark_idx;
    logic                      r_clr, n_clr;
    logic [16:0]               r_ratio, n_ratio;
    logic [17:0]               r_mean, n_mean;
    logic [15:0]               r_rms, n_rms;
    logic                      r_div_start, n_div_start;
    logic [NW-1:0]             r_div_num, n_div_num;
    logic [CNT_W-1:0]          r_div_den, n_div_den;
    logic                      r_sq_start, n_sq_start;
    logic [SQ_W-1:0]           r_sq_in, n_sq_in;
    gmp_pkg::t_result          r_out, n_out;
    logic                      r_out_valid, n_out_valid;

    logic                      ram_we;
    logic                      cell_wr;
    logic [ENT_W-1:0]          ram_rdata;
    logic                      div_done;
    logic [NW-1:0]             div_quot;
    logic                      sq_done;
    logic [RT_W-1:0]           sq_root;
    logic [CNT_W-1:0]          n_min;
    logic [DIRW-1:0]           adiff;
    logic [DIRW:0]             ddbl;
    logic [DIRW:0]             dmod;
    logic [DIRW:0]             fold;

    gmp_pkg::t_query           w_q   [MAX_MINUTIAE+1];
    gmp_pkg::t_best            w_b   [MAX_MINUTIAE+1];
    logic [IDX_W-1:0]          w_idx [MAX_MINUTIAE+1];

    gmp_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_MINUTIAE)
    ) u_first_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (r_n1[IDX_W-1:0]),
        .i_wr_data ({i_item.x_pos[CW-1:0], i_item.y_pos[CW-1:0], i_item.direction}),
        .i_rd_addr (r_i[IDX_W-1:0]),
        .o_rd_data (ram_rdata)
    );

    assign w_q[0] = r_query;
    assign w_b[0] = r_seed;
    assign w_idx[0] = '0;

    for (genvar k = 0; k < MAX_MINUTIAE; k++) begin : g_cells
        gmp_cell #(
            .IDX_W    (IDX_W),
            .CNT_W    (CNT_W),
            .CELL_IDX (k)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_wr_en    (cell_wr),
            .i_wr_idx   (r_n2[IDX_W-1:0]),
            .i_wr_x     (i_item.x_pos[CW-1:0]),
            .i_wr_y     (i_item.y_pos[CW-1:0]),
            .i_wr_dir   (i_item.direction),
            .i_fill     (r_n2),
            .i_clr      (r_clr),
            .i_mark_en  (r_mark_en),
            .i_mark_idx (r_mark_idx),
            .i_query    (w_q[k]),
            .o_query    (w_q[k+1]),
            .i_best     (w_b[k]),
            .i_best_idx (w_idx[k]),
            .o_best     (w_b[k+1]),
            .o_best_idx (w_idx[k+1])
        );
    end

    gmp_div #(
        .NW (NW),
        .DW (CNT_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (r_div_num),
        .i_den   (r_div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    gmp_sqrt #(
        .SW (SQ_W)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_sq_start),
        .i_rad   (r_sq_in),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    // folded angle difference in degrees, 0..180
    always_comb begin
        adiff = (r_qdir > w_b[MAX_MINUTIAE].dir) ? r_qdir - w_b[MAX_MINUTIAE].dir
                                                 : w_b[MAX_MINUTIAE].dir - r_qdir;
        ddbl = {adiff, 1'b0};
        dmod = (ddbl >= FULL_C) ? ddbl - FULL_C : ddbl;
        fold = (dmod > HALF_C) ? FULL_C - dmod : dmod;
        n_min = (r_n1 < r_n2) ? r_n1 : r_n2;
    end

    always_comb begin
        n_state = r_state;
        n_radius = i_cfg_wr_en ? i_cfg_wr_data : r_radius;
        n_n1 = r_n1;
        n_n2 = r_n2;
        n_drop = r_drop;
        n_mark1 = r_mark1;
        n_r = r_r;
        n_r2 = r_r2;
        n_i = r_i;
        n_common = r_common;
        n_dsum = r_dsum;
        n_asum = r_asum;
        n_fold = r_fold;
        n_qdir = r_qdir;
        n_query = r_query;
        n_query.valid = 1'b0;
        n_seed = '0;
        n_seed.valid = r_query.valid;
        n_mark_en = 1'b0;
        n_mark_idx = r_mark_idx;
        n_clr = 1'b0;
        n_ratio = r_ratio;
        n_mean = r_mean;
        n_rms = r_rms;
        n_div_start = 1'b0;
        n_div_num = r_div_num;
        n_div_den = r_div_den;
        n_sq_start = 1'b0;
        n_sq_in = r_sq_in;
        n_out = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        ram_we = 1'b0;
        cell_wr = 1'b0;
        o_in_ready = (r_state == gmp_pkg::ST_IDLE);

        unique case (r_state)
            gmp_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    case (i_item.mode)
                        gmp_pkg::MODE_LOAD_FIRST: begin
                            if (r_n1 < MAX_C) begin
                                ram_we = 1'b1;
                                n_n1 = r_n1 + CNT_W'(1);
                            end else begin
                                n_drop = 1'b1;
                            end
                        end
                        gmp_pkg::MODE_LOAD_SECOND: begin
                            if (r_n2 < MAX_C) begin
                                cell_wr = 1'b1;
                                n_n2 = r_n2 + CNT_W'(1);
                            end else begin
                                n_drop = 1'b1;
                            end
                        end
                        gmp_pkg::MODE_COMPARE: begin
                            n_common = '0;
                            n_dsum = '0;
                            n_asum = '0;
                            n_ratio = '0;
                            n_mean = '0;
                            n_rms = '0;
                            n_r = '0;
                            if ((i_item.finger_first == i_item.finger_second) &&
                                (r_n1 != '0) && (r_n2 != '0)) begin
                                n_state = gmp_pkg::ST_PASS;
                            end else begin
                                n_state = gmp_pkg::ST_OUT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            gmp_pkg::ST_PASS: begin
                if ((r_r > {1'b0, r_radius}) || (r_common >= r_n1) || (r_common >= r_n2)) begin
                    n_div_start = 1'b1;
                    n_div_num = NW'(r_common) << QS;
                    n_div_den = n_min;
                    n_state = gmp_pkg::ST_RATIO;
                end else begin
                    n_r2 = r_r[RADW-1:0] * r_r[RADW-1:0];
                    n_i = '0;
                    n_state = gmp_pkg::ST_READ;
                end
            end
            gmp_pkg::ST_READ: begin
                if (r_i == r_n1) begin
                    n_r = r_r + (RADW + 1)'(1);
                    n_state = gmp_pkg::ST_PASS;
                end else if (r_mark1[r_i[IDX_W-1:0]]) begin
                    n_i = r_i + CNT_W'(1);
                end else begin
                    n_state = gmp_pkg::ST_QUERY;
                end
            end
            gmp_pkg::ST_QUERY: begin
                n_query.valid = 1'b1;
                n_query.x = ram_rdata[ENT_W-1 -: CW];
                n_query.y = ram_rdata[DIRW +: CW];
                n_qdir = ram_rdata[DIRW-1:0];
                n_state = gmp_pkg::ST_WAIT;
            end
            gmp_pkg::ST_WAIT: begin
                if (w_b[MAX_MINUTIAE].valid) begin
                    if (w_b[MAX_MINUTIAE].found &&
                        (w_b[MAX_MINUTIAE].d2 <= D2W'(r_r2))) begin
                        n_mark1[r_i[IDX_W-1:0]] = 1'b1;
                        n_mark_en = 1'b1;
                        n_mark_idx = w_idx[MAX_MINUTIAE];
                        n_common = r_common + CNT_W'(1);
                        n_fold = fold[gmp_pkg::FOLD_W-1:0];
                        n_sq_start = 1'b1;
                        n_sq_in = SQ_W'(w_b[MAX_MINUTIAE].d2) << QS;
                        n_state = gmp_pkg::ST_DSQRT;
                    end else begin
                        n_i = r_i + CNT_W'(1);
                        n_state = gmp_pkg::ST_READ;
                    end
                end
            end
            gmp_pkg::ST_DSQRT: begin
                if (sq_done) begin
                    n_dsum = r_dsum + DS_W'(sq_root);
                    n_asum = r_asum + A_W'(r_fold) * A_W'(r_fold);
                    n_i = r_i + CNT_W'(1);
                    n_state = gmp_pkg::ST_READ;
                end
            end
            gmp_pkg::ST_RATIO: begin
                if (div_done) begin
                    n_ratio = 17'(div_quot);
                    if (r_common == '0) begin
                        n_state = gmp_pkg::ST_OUT;
                    end else begin
                        n_div_start = 1'b1;
                        n_div_num = NW'(r_dsum);
                        n_div_den = r_common;
                        n_state = gmp_pkg::ST_MEAN;
                    end
                end
            end
            gmp_pkg::ST_MEAN: begin
                if (div_done) begin
                    n_mean = 18'(div_quot);
                    n_div_start = 1'b1;
                    n_div_num = NW'(r_asum) << QS;
                    n_state = gmp_pkg::ST_ADIV;
                end
            end
            gmp_pkg::ST_ADIV: begin
                if (div_done) begin
                    n_sq_start = 1'b1;
                    n_sq_in = SQ_W'(div_quot);
                    n_state = gmp_pkg::ST_ASQRT;
                end
            end
            gmp_pkg::ST_ASQRT: begin
                if (sq_done) begin
                    n_rms = 16'(sq_root);
                    n_state = gmp_pkg::ST_OUT;
                end
            end
            gmp_pkg::ST_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out.count_first = 9'(r_n1);
                    n_out.count_second = 9'(r_n2);
                    n_out.common_count = 9'(r_common);
                    n_out.ratio_q16 = r_ratio;
                    n_out.mean_distance_q8 = r_mean;
                    n_out.rms_angle_q8 = r_rms;
                    n_out.overflow = r_drop;
                    n_out_valid = 1'b1;
                    n_n1 = '0;
                    n_n2 = '0;
                    n_drop = 1'b0;
                    n_mark1 = '0;
                    n_clr = 1'b1;
                    n_state = gmp_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = gmp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gmp_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADW'(gmp_pkg::RADIUS_RESET);
            r_n1 <= '0;
            r_n2 <= '0;
            r_drop <= 1'b0;
            r_mark1 <= '0;
            r_query <= '0;
            r_seed <= '0;
            r_mark_en <= 1'b0;
            r_clr <= 1'b0;
            r_div_start <= 1'b0;
            r_sq_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_radius <= n_radius;
            r_n1 <= n_n1;
            r_n2 <= n_n2;
            r_drop <= n_drop;
            r_mark1 <= n_mark1;
            r_query <= n_query;
            r_seed <= n_seed;
            r_mark_en <= n_mark_en;
            r_clr <= n_clr;
            r_div_start <= n_div_start;
            r_sq_start <= n_sq_start;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_r <= n_r;
        r_r2 <= n_r2;
        r_i <= n_i;
        r_common <= n_common;
        r_dsum <= n_dsum;
        r_asum <= n_asum;
        r_fold <= n_fold;
        r_qdir <= n_qdir;
        r_mark_idx <= n_mark_idx;
        r_ratio <= n_ratio;
        r_mean <= n_mean;
        r_rms <= n_rms;
        r_div_num <= n_div_num;
        r_div_den <= n_div_den;
        r_sq_in <= n_sq_in;
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_result = r_out;

endmodule

// ===== hdl/gmp_checker.sv =====
// Port-level checks on the pairing results, bound to the top level
`include "greedy_minutiae_pairing_assert.svh"

module gmp_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input gmp_pkg::t_result i_result
);

    `GMP_ASSERT_IMPLY(a_common_bound, i_out_valid, (i_result.common_count <= i_result.count_first) && (i_result.common_count <= i_result.count_second), "pair count exceeds a set size")
    `GMP_ASSERT_IMPLY(a_no_pair_zero, i_out_valid && (i_result.common_count == 9'd0), (i_result.ratio_q16 == 17'd0) && (i_result.mean_distance_q8 == 18'd0) && (i_result.rms_angle_q8 == 16'd0), "nonzero statistics without pairs")
    `GMP_ASSERT_IMPLY(a_ratio_bound, i_out_valid, i_result.ratio_q16 <= 17'd65536, "ratio above one")
    `GMP_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_result), "stalled result changed")

endmodule

bind greedy_minutiae_pairing gmp_checker u_gmp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_result    (o_result)
);

// ===== sim/tb_greedy_minutiae_pairing.sv =====
// Testbench for greedy_minutiae_pairing: directed table, then random pairing sets
`timescale 1ns / 100ps

module tb_greedy_minutiae_pairing;
    import gmp_pkg::*;

    localparam int IDLE_LIMIT = 2000000;
    localparam int NUM_ITEMS  = 1250;

    typedef struct {
        t_item   item;
        bit      typed;
        t_result res;
    } t_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    t_item      i_item = '0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    t_result    o_result;
    logic       i_cfg_wr_en = 1'b0;
    logic [RADIUS_W-1:0] i_cfg_wr_data = '0;

    greedy_minutiae_pairing i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_item        (i_item),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_result      (o_result),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always #5 i_clk = ~i_clk;

    // pairing predictor state
    logic [13:0] set1_x[MAX_MINUTIAE], set1_y[MAX_MINUTIAE];
    logic [13:0] set2_x[MAX_MINUTIAE], set2_y[MAX_MINUTIAE];
    logic [7:0]  set1_dir[MAX_MINUTIAE], set2_dir[MAX_MINUTIAE];
    int          fill1, fill2;
    bit          dropped;
    int          radius_now;

    t_result     pending_results[$];
    t_row        plan[$];
    int          errors = 0;
    int          items_sent = 0;
    int          idle_cycles = 0;
    int          hold_len = 0;
    bit          quiet = 0;

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic int fold_angle(input int a, input int b);
        int d;
        d = (2 * (a > b ? a - b : b - a)) % FULL_TURN;
        return d > HALF_TURN ? FULL_TURN - d : d;
    endfunction

    // updates the set state and returns 1 with the pairing result on a compare
    function automatic bit predict_pairing(input t_item it, output t_result res);
        bit              used1[MAX_MINUTIAE], used2[MAX_MINUTIAE];
        longint unsigned best, d2, dx, dy, dsum, asum;
        int              common, bj, f, mn;
        bit              found;
        res = '0;
        if (it.mode == MODE_LOAD_FIRST || it.mode == MODE_LOAD_SECOND) begin
            if (it.mode == MODE_LOAD_FIRST) begin
                if (fill1 >= MAX_MINUTIAE) dropped = 1;
                else begin
                    set1_x[fill1] = it.x_pos; set1_y[fill1] = it.y_pos;
                    set1_dir[fill1] = it.direction; fill1++;
                end
            end else begin
                if (fill2 >= MAX_MINUTIAE) dropped = 1;
                else begin
                    set2_x[fill2] = it.x_pos; set2_y[fill2] = it.y_pos;
                    set2_dir[fill2] = it.direction; fill2++;
                end
            end
            return 0;
        end
        if (it.mode != MODE_COMPARE) return 0;
        common = 0; dsum = 0; asum = 0;
        foreach (used1[k]) begin used1[k] = 0; used2[k] = 0; end
        if (it.finger_first == it.finger_second && fill1 != 0 && fill2 != 0) begin
            for (int r = 0; r <= radius_now; r++) begin
                if (common >= fill1 || common >= fill2) break;
                for (int i = 0; i < fill1; i++) begin
                    if (used1[i]) continue;
                    best = 64'd10000000000; bj = 0; found = 0;
                    for (int j = 0; j < fill2; j++) begin
                        if (used2[j]) continue;
                        dx = set1_x[i] > set2_x[j] ? set1_x[i] - set2_x[j] : set2_x[j] - set1_x[i];
                        dy = set1_y[i] > set2_y[j] ? set1_y[i] - set2_y[j] : set2_y[j] - set1_y[i];
                        d2 = dx * dx + dy * dy;
                        if (d2 < best) begin best = d2; bj = j; found = 1; end
                    end
                    if (found && best <= longint'(r) * r) begin
                        f = fold_angle(set1_dir[i], set2_dir[bj]);
                        used1[i] = 1; used2[bj] = 1;
                        dsum += int_sqrt(best << 16);
                        asum += longint'(f) * f;
                        common++;
                    end
                end
            end
            mn = fill1 < fill2 ? fill1 : fill2;
            res.ratio_q16 = (longint'(common) << 16) / mn;
            if (common != 0) begin
                res.mean_distance_q8 = dsum / common;
                res.rms_angle_q8 = int_sqrt((asum << 16) / common);
            end
        end
        res.count_first = fill1;
        res.count_second = fill2;
        res.common_count = common;
        res.overflow = dropped;
        fill1 = 0; fill2 = 0; dropped = 0;
        return 1;
    endfunction

    function automatic t_item make_item(input logic [1:0] m, input int x, input int y,
                                        input int d, input int f1 = 0, input int f2 = 0);
        t_item it;
        it.mode = m; it.x_pos = x; it.y_pos = y; it.direction = d;
        it.finger_first = f1; it.finger_second = f2;
        return it;
    endfunction

    task automatic add_row(input t_item it, input bit typed = 0, input t_result res = '0);
        t_row rw;
        rw.item = it; rw.typed = typed; rw.res = res;
        plan.push_back(rw);
    endtask

    task automatic send_row(input t_row rw);
        t_result res;
        @(negedge i_clk);
        if (!quiet) begin
            while ($urandom_range(99) < 24) begin
                i_in_valid = 1'b0;
                @(negedge i_clk);
            end
        end
        i_in_valid = 1'b1;
        i_item = rw.item;
        do @(posedge i_clk); while (!o_in_ready);
        if (rw.item.mode != 2'd3) items_sent++;
        if (predict_pairing(rw.item, res))
            pending_results.push_back(rw.typed ? rw.res : res);
    endtask

    task automatic send_item(input t_item it);
        t_row rw;
        rw.item = it; rw.typed = 0; rw.res = '0;
        send_row(rw);
    endtask

    task automatic settle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_radius(input int r);
        settle();
        i_cfg_wr_en = 1'b1;
        i_cfg_wr_data = r;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
        radius_now = r;
    endtask

    // one comparison: mostly jittered copies of the first set, some strays
    task automatic random_compare(input int max_n, input int jit);
        int n1, n2, bx, by, k1, k2, f1;
        t_item it;
        n1 = $urandom_range(max_n);
        n2 = $urandom_range(max_n);
        bx = $urandom_range(16383);
        by = $urandom_range(16383);
        k1 = 0; k2 = 0;
        while (k1 < n1 || k2 < n2) begin
            if (k2 >= n2 || (k1 < n1 && $urandom_range(1))) begin
                it = make_item(MODE_LOAD_FIRST, (bx + 8 * k1) & 14'h3fff,
                               (by + 5 * k1) & 14'h3fff, $urandom_range(179));
                if ($urandom_range(9) == 0) begin
                    it.x_pos = $urandom_range(16383); it.y_pos = $urandom_range(16383);
                end
                k1++;
            end else begin
                it = make_item(MODE_LOAD_SECOND,
                               (bx + 8 * k2 + $urandom_range(2 * jit) - jit) & 14'h3fff,
                               (by + 5 * k2 + $urandom_range(2 * jit) - jit) & 14'h3fff,
                               $urandom_range(179));
                if ($urandom_range(9) == 0) begin
                    it.x_pos = $urandom_range(16383); it.y_pos = $urandom_range(16383);
                end
                k2++;
            end
            send_item(it);
            if ($urandom_range(29) == 0) begin
                it.mode = 2'd3;
                it.x_pos = $urandom_range(16383);
                send_item(it);
            end
        end
        f1 = $urandom_range(15);
        send_item(make_item(MODE_COMPARE, $urandom_range(16383), $urandom_range(16383),
                            $urandom_range(179), f1,
                            $urandom_range(6) == 0 ? $urandom_range(15) : f1));
    endtask

    // receiver: random stalls, or a counted hold-off requested by the stimulus
    always @(negedge i_clk) begin
        if (hold_len > 0) begin
            i_out_ready <= 1'b0;
            hold_len <= hold_len - 1;
        end else begin
            i_out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 24);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with none expected, actual %p", $time, o_result);
                errors++;
            end else begin
                t_result exp_res;
                exp_res = pending_results.pop_front();
                if (o_result !== exp_res) begin
                    $display("%0t: result mismatch, expected %p, actual %p",
                             $time, exp_res, o_result);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || !i_rst_n)
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL greedy_minutiae_pairing");
            $finish;
        end else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        t_item it;
        fill1 = 0; fill2 = 0; dropped = 0;
        radius_now = RADIUS_RESET;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table
        add_row(make_item(MODE_COMPARE, 0, 0, 0), 1, '0);
        add_row(make_item(MODE_LOAD_FIRST, 0, 0, 0));
        add_row(make_item(MODE_LOAD_SECOND, 0, 0, 0));
        add_row(make_item(MODE_COMPARE, 0, 0, 0, 0, 0), 1,
                '{9'd1, 9'd1, 9'd1, 17'd65536, 18'd0, 16'd0, 1'b0});
        add_row(make_item(MODE_LOAD_FIRST, 16383, 16383, 179));
        add_row(make_item(MODE_LOAD_SECOND, 16383, 16383, 89));
        add_row(make_item(MODE_COMPARE, 0, 0, 0, 15, 15), 1,
                '{9'd1, 9'd1, 9'd1, 17'd65536, 18'd0, 16'd46080, 1'b0});
        add_row(make_item(MODE_LOAD_FIRST, 100, 100, 10));
        add_row(make_item(MODE_LOAD_SECOND, 100, 100, 10));
        add_row(make_item(MODE_COMPARE, 0, 0, 0, 15, 0), 1,
                '{9'd1, 9'd1, 9'd0, 17'd0, 18'd0, 16'd0, 1'b0});
        add_row(make_item(2'd3, 12345, 6789, 55, 3, 4));
        add_row(make_item(MODE_LOAD_FIRST, 0, 0, 0));
        add_row(make_item(MODE_LOAD_SECOND, 16383, 16383, 179));
        add_row(make_item(MODE_COMPARE, 0, 0, 0, 7, 7), 1,
                '{9'd1, 9'd1, 9'd0, 17'd0, 18'd0, 16'd0, 1'b0});
        // equal distances: lower index wins
        add_row(make_item(MODE_LOAD_FIRST, 5, 5, 0));
        add_row(make_item(MODE_LOAD_FIRST, 9, 9, 170));
        add_row(make_item(MODE_LOAD_SECOND, 2, 5, 45));
        add_row(make_item(MODE_LOAD_SECOND, 8, 5, 90));
        add_row(make_item(MODE_LOAD_SECOND, 12, 13, 3));
        add_row(make_item(MODE_COMPARE, 0, 0, 0, 2, 2));
        add_row(make_item(MODE_LOAD_SECOND, 7, 7, 1));
        add_row(make_item(MODE_COMPARE, 0, 0, 0, 9, 9));
        foreach (plan[k]) send_row(plan[k]);

        // full first set, then full second set: each extra load is dropped
        write_radius(1);
        for (int k = 0; k <= MAX_MINUTIAE; k++)
            send_item(make_item(MODE_LOAD_FIRST, $urandom_range(16383),
                                $urandom_range(16383), $urandom_range(179)));
        send_item(make_item(MODE_LOAD_SECOND, 1, 1, 1));
        send_item(make_item(MODE_COMPARE, 0, 0, 0, 1, 2));
        for (int k = 0; k <= MAX_MINUTIAE; k++)
            send_item(make_item(MODE_LOAD_SECOND, $urandom_range(16383),
                                $urandom_range(16383), $urandom_range(179)));
        send_item(make_item(MODE_COMPARE, 0, 0, 0, 4, 5));

        // widest radius: an unpairable couple runs every pass, then a couple that pairs at r = 500
        write_radius(1023);
        send_item(make_item(MODE_LOAD_FIRST, 0, 16383, 0));
        send_item(make_item(MODE_LOAD_SECOND, 16383, 0, 179));
        send_item(make_item(MODE_COMPARE, 0, 0, 0, 6, 6));
        send_item(make_item(MODE_LOAD_FIRST, 40, 40, 20));
        send_item(make_item(MODE_LOAD_SECOND, 540, 40, 120));
        send_item(make_item(MODE_COMPARE, 0, 0, 0, 6, 6));

        // output held off while compares keep coming; long enough for a
        // second compare to finish and stall the input behind the first result
        write_radius(3);
        hold_len = 12000;
        for (int k = 0; k < 6; k++) random_compare(3, 2);
        settle();

        // clean stretch with no idling on either side
        quiet = 1;
        for (int k = 0; k < 10; k++) random_compare(5, 3);
        quiet = 0;

        while (items_sent < NUM_ITEMS) begin
            write_radius($urandom_range(7) == 0 ? $urandom_range(1, 12) : $urandom_range(1, 6));
            for (int k = 0; k < 20 && items_sent < NUM_ITEMS; k++)
                random_compare(6, $urandom_range(1, 4));
        end
        write_radius(RADIUS_RESET);
        random_compare(4, 5);

        settle();
        repeat (30) @(negedge i_clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("PASS greedy_minutiae_pairing");
        else
            $display("FAIL greedy_minutiae_pairing");
        $finish;
    end

endmodule
